[hdl/clt_pkg.sv]
`timescale 1ns / 1ps

package clt_pkg;

    // Token limit per string and the counter width it needs.
    localparam int MAX_TOKENS  = 1024;
    localparam int TOK_NEED_W  = $clog2(MAX_TOKENS + 1);
    localparam int CNT_W       = (TOK_NEED_W > 11) ? TOK_NEED_W : 11;

    // One input byte gives at most this many results.
    localparam int MAX_RESULTS = 3;
    localparam int RES_N_W     = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [2:0] {
        MODE_SKIP  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_QUOTE = 3'd2,
        MODE_BLOCK = 3'd3,
        MODE_DONE  = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic             slash;
        logic             star;
        logic [CNT_W-1:0] tokens;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [9:0]  token_number;
        logic        token_end;
        logic [10:0] token_count;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [RES_N_W-1:0]        n;
        logic                      fin;
    } bundle_t;

    // Append one result, tagged with the current token counter.
    function automatic bundle_t bundle_put(
        input bundle_t          b,
        input logic [7:0]       c,
        input logic             e,
        input logic [CNT_W-1:0] tok
    );
        bundle_t          nb;
        logic [CNT_W-1:0] num;
        nb  = b;
        num = tok - CNT_W'(1);
        if (b.n < RES_N_W'(MAX_RESULTS))
        begin
            nb.res[RES_IDX_W'(b.n)].out_char     = c;
            nb.res[RES_IDX_W'(b.n)].token_number = (tok == '0) ? 10'd0 : num[9:0];
            nb.res[RES_IDX_W'(b.n)].token_end    = e;
            nb.res[RES_IDX_W'(b.n)].token_count  = tok[10:0];
            nb.n = b.n + RES_N_W'(1);
        end
        return nb;
    endfunction

endpackage

[hdl/command_line_tokenizer_top.sv]
`timescale 1ns / 1ps

// Command-line tokenizer. Takes one string byte per input beat and returns
// token bytes, each tagged with its token number, with a terminator beat
// closing every token; a status beat marks a string that ends with nothing
// else to report. An input beat is taken every cycle while out_ready is high
// and each byte gives at most one result beat; a byte that gives two or three
// result beats holds the input until its last beat is taken, since the output
// channel carries one beat per cycle, while out_ready is high, from the result
// register. The parser state update is combinational logic ahead of the state
// register. The ignore_quotes register is written through the cfg channel,
// which is always ready, and should be changed only while idle.
module command_line_tokenizer_top
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        is_last,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic [9:0]  token_number,
    output logic        token_end,
    output logic        string_done,
    output logic [10:0] token_count,
    output logic        last_of_run
);

    parse_state_t         state_reg;
    parse_state_t         state_next;
    bundle_t              bundle_reg;
    bundle_t              bundle_next;
    logic                 bvalid_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic                 iq_reg;
    logic                 is_final;
    logic                 accept;
    result_t              cur;

    clt_step u_step (
        .st            (state_reg),
        .ch            (ch),
        .is_last       (is_last),
        .ignore_quotes (iq_reg),
        .st_next       (state_next),
        .bundle        (bundle_next)
    );

    // Output side: walk the result register one beat at a time.
    assign cur       = bundle_reg.res[idx_reg];
    assign is_final  = (idx_reg == RES_IDX_W'(bundle_reg.n - RES_N_W'(1)));
    assign in_ready  = !bvalid_reg || (out_ready && is_final);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid    = bvalid_reg;
    assign out_char     = cur.out_char;
    assign token_number = cur.token_number;
    assign token_end    = cur.token_end;
    assign token_count  = cur.token_count;
    assign last_of_run  = is_final;
    assign string_done  = is_final && bundle_reg.fin;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iq_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            iq_reg <= cfg_data;
        end
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '{mode: MODE_SKIP, slash: 1'b0, star: 1'b0, tokens: '0};
            bvalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                if (bundle_next.n != '0)
                begin
                    bvalid_reg <= 1'b1;
                    idx_reg    <= '0;
                end
                else if (bvalid_reg)
                begin
                    bvalid_reg <= 1'b0;
                end
            end
            else if (bvalid_reg && out_ready)
            begin
                if (is_final)
                begin
                    bvalid_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + RES_IDX_W'(1);
                end
            end
        end
    end

    // Result payload, loaded with each byte that gives results.
    always_ff @(posedge clk)
    begin
        if (accept && bundle_next.n != '0)
        begin
            bundle_reg <= bundle_next;
        end
    end

endmodule

[hdl/clt_step.sv]
`timescale 1ns / 1ps

// Parser step: from the current state and one input byte, the next state and
// the results this byte gives.
module clt_step
    import clt_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   ch,
    input  logic         is_last,
    input  logic         ignore_quotes,
    output parse_state_t st_next,
    output bundle_t      bundle
);

    always_comb
    begin
        parse_state_t s;
        bundle_t      b;
        logic         fin;
        logic         ended;
        logic         do_word;
        logic         q_act;

        s       = st;
        b       = '0;
        fin     = 1'b0;
        do_word = 1'b0;
        ended   = (ch == CH_NUL) || is_last;
        q_act   = (ch == CH_QUOTE) && !ignore_quotes;

        // Content byte.
        if (ch != CH_NUL)
        begin
            case (s.mode)
                MODE_SKIP, MODE_WORD:
                begin
                    if (s.slash)
                    begin
                        s.slash = 1'b0;
                        if (ch == CH_SLASH || ch == CH_STAR)
                        begin
                            if (s.mode == MODE_WORD)
                            begin
                                b = bundle_put(b, CH_NUL, 1'b1, s.tokens);
                                s.mode = MODE_SKIP;
                                if (s.tokens >= CNT_W'(MAX_TOKENS))
                                begin
                                    s.mode = MODE_DONE;
                                    fin    = 1'b1;
                                end
                            end
                            if (s.mode != MODE_DONE)
                            begin
                                if (ch == CH_SLASH)
                                begin
                                    s.mode = MODE_DONE;
                                    fin    = 1'b1;
                                end
                                else
                                begin
                                    s.mode = MODE_BLOCK;
                                    s.star = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            // The held slash turns out to be token content.
                            if (s.mode == MODE_SKIP)
                            begin
                                s.tokens = s.tokens + CNT_W'(1);
                                s.mode   = MODE_WORD;
                            end
                            b = bundle_put(b, CH_SLASH, 1'b0, s.tokens);
                            do_word = 1'b1;
                        end
                    end
                    else if (s.mode == MODE_SKIP)
                    begin
                        if (ch > CH_SPACE)
                        begin
                            if (ch == CH_SLASH)
                            begin
                                s.slash = 1'b1;
                            end
                            else if (q_act)
                            begin
                                s.tokens = s.tokens + CNT_W'(1);
                                s.mode   = MODE_QUOTE;
                            end
                            else
                            begin
                                s.tokens = s.tokens + CNT_W'(1);
                                s.mode   = MODE_WORD;
                                b = bundle_put(b, ch, 1'b0, s.tokens);
                            end
                        end
                    end
                    else
                    begin
                        do_word = 1'b1;
                    end

                    // Byte inside a regular token.
                    if (do_word)
                    begin
                        if (ch <= CH_SPACE || q_act)
                        begin
                            b = bundle_put(b, CH_NUL, 1'b1, s.tokens);
                            s.mode = MODE_SKIP;
                            if (s.tokens >= CNT_W'(MAX_TOKENS))
                            begin
                                s.mode = MODE_DONE;
                                fin    = 1'b1;
                            end
                            if (q_act && s.mode != MODE_DONE)
                            begin
                                s.tokens = s.tokens + CNT_W'(1);
                                s.mode   = MODE_QUOTE;
                            end
                        end
                        else if (ch == CH_SLASH)
                        begin
                            s.slash = 1'b1;
                        end
                        else
                        begin
                            b = bundle_put(b, ch, 1'b0, s.tokens);
                        end
                    end
                end

                MODE_QUOTE:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        b = bundle_put(b, CH_NUL, 1'b1, s.tokens);
                        s.mode = MODE_SKIP;
                        if (s.tokens >= CNT_W'(MAX_TOKENS))
                        begin
                            s.mode = MODE_DONE;
                            fin    = 1'b1;
                        end
                    end
                    else
                    begin
                        b = bundle_put(b, ch, 1'b0, s.tokens);
                    end
                end

                MODE_BLOCK:
                begin
                    if (s.star && ch == CH_SLASH)
                    begin
                        s.mode = MODE_SKIP;
                        s.star = 1'b0;
                    end
                    else
                    begin
                        s.star = (ch == CH_STAR);
                    end
                end

                default:
                begin
                end
            endcase
        end

        // End of the string: flush a held slash and close an open token.
        if (ended)
        begin
            if ((s.mode == MODE_SKIP || s.mode == MODE_WORD) && s.slash)
            begin
                if (s.mode == MODE_SKIP)
                begin
                    s.tokens = s.tokens + CNT_W'(1);
                end
                s.mode = MODE_WORD;
                b = bundle_put(b, CH_SLASH, 1'b0, s.tokens);
            end
            if (s.mode == MODE_WORD || s.mode == MODE_QUOTE)
            begin
                b = bundle_put(b, CH_NUL, 1'b1, s.tokens);
            end
            if (s.mode != MODE_DONE)
            begin
                fin = 1'b1;
            end
        end

        // Status result when parsing finishes on a byte with no other result.
        if (fin && b.n == '0)
        begin
            b = bundle_put(b, CH_NUL, 1'b0, s.tokens);
            b.res[0].token_number = 10'd0;
        end
        b.fin = fin;

        if (ended)
        begin
            s.mode   = MODE_SKIP;
            s.slash  = 1'b0;
            s.star   = 1'b0;
            s.tokens = '0;
        end

        st_next = s;
        bundle  = b;
    end

endmodule
